// ===== hw/rtl/wcpu_pkg.sv =====
package wcpu_pkg;

  // console and print ports, and the halt word, in the address space
  localparam logic [15:0] PortChar = 16'hff00;
  localparam logic [15:0] PortHex  = 16'hff01;
  localparam logic [15:0] PortDec  = 16'hff02;
  localparam logic [15:0] HaltAddr = 16'hffff;

  // out_kind codes
  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindChar = 2'd1;
  localparam logic [1:0] KindHex  = 2'd2;
  localparam logic [1:0] KindDec  = 2'd3;

  typedef struct packed {
    logic        command;
    logic [15:0] load_address;
    logic [15:0] load_data;
    logic [15:0] console_first;
    logic [15:0] console_second;
  } item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [15:0] out_value;
    logic [1:0]  console_used;
    logic        halted;
  } result_t;

endpackage

// ===== hw/rtl/word_cpu_instruction_step.sv =====
// Channel   Handshake                      Payload
// -------   -----------------------------  ---------------------------
// command   start high, busy low           item_i   (wcpu_pkg::item_t)
// result    out_valid_o, one cycle only    result_o (wcpu_pkg::result_t)
//
// A load transfer writes its word in the idle state and goes straight to the
// result state, as does a step on a halted machine. A step's length is set by
// the single memory port (fetch, immediates, operand reads and the write each
// use it in turn); divide and remainder add a pass through the one-bit-per-cycle
// divider. After reset a clearing pass zeroes all 65536 memory words with busy high.
// The result receiver cannot stall; each result is shown for exactly one cycle.
module word_cpu_instruction_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  wcpu_pkg::item_t   item_i,
  output logic              out_valid_o,
  output wcpu_pkg::result_t result_o
);

  localparam logic [3:0] StClr   = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StFetch = 4'd2;
  localparam logic [3:0] StDec   = 4'd3;
  localparam logic [3:0] StImm   = 4'd4;
  localparam logic [3:0] StExec  = 4'd5;
  localparam logic [3:0] StLoad  = 4'd6;
  localparam logic [3:0] StLwait = 4'd7;
  localparam logic [3:0] StAlu   = 4'd8;
  localparam logic [3:0] StDiv   = 4'd9;
  localparam logic [3:0] StDivE  = 4'd10;
  localparam logic [3:0] StPopW  = 4'd11;
  localparam logic [3:0] StDone  = 4'd12;

  localparam logic [3:0] OpMov = 4'h0;
  localparam logic [3:0] OpAdd = 4'h1;
  localparam logic [3:0] OpMul = 4'h2;
  localparam logic [3:0] OpDiv = 4'h3;
  localparam logic [3:0] OpRem = 4'h4;
  localparam logic [3:0] OpShr = 4'h5;
  localparam logic [3:0] OpShl = 4'h6;
  localparam logic [3:0] OpOr  = 4'h7;
  localparam logic [3:0] OpAnd = 4'h8;
  localparam logic [3:0] OpXor = 4'h9;
  localparam logic [3:0] OpEq  = 4'hA;
  localparam logic [3:0] OpGtu = 4'hB;
  localparam logic [3:0] OpGts = 4'hC;
  localparam logic [3:0] OpPush = 4'hD;
  localparam logic [3:0] OpPop  = 4'hE;
  localparam logic [3:0] OpCall = 4'hF;

  localparam logic [2:0] RegPc = 3'd5;
  localparam logic [2:0] RegSp = 3'd6;
  localparam logic [2:0] RegImm = 3'd7;

  // main memory, single port, registered read
  logic [15:0] mem_q [65536];
  logic [15:0] mem_rdata_q;
  logic        mem_we;
  logic [15:0] mem_addr, mem_wdata;

  logic [3:0]  state_q, state_d;
  logic [15:0] clr_q, clr_d;
  logic [15:0] rf_q [5];
  logic [15:0] rf_d [5];
  logic [15:0] pc_q, pc_d, sp_q, sp_d;
  logic        truth_q, truth_d, halt_q, halt_d;
  wcpu_pkg::item_t item_q, item_d;
  logic [15:0] ir_q, ir_d;
  logic        k_q, k_d;
  logic [15:0] imm_addr_q, imm_addr_d;
  logic        p0_mem_q, p0_mem_d, p1_mem_q, p1_mem_d;
  logic [15:0] p0_where_q, p0_where_d, p1_where_q, p1_where_d;
  logic        ld_sel_q, ld_sel_d, ld_two_q, ld_two_d;
  logic [15:0] a_q, a_d, b_q, b_d;
  logic [31:0] dvd_q, dvd_d;
  logic [15:0] dvs_q, dvs_d, rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [1:0]  kind_q, kind_d, con_q, con_d;
  logic [15:0] val_q, val_d;

  // combinational helpers
  logic [2:0]  rf_raddr;
  logic [15:0] rf_rdata;
  logic        rf_we;
  logic [2:0]  rf_waddr;
  logic [15:0] rf_wdata;
  logic        st_en, st_mem;
  logic [15:0] st_where, st_val;
  logic [3:0]  mode, op;
  logic        alt, cond;
  logic        res_en;
  logic [15:0] res;
  logic [15:0] held;
  logic        lsel_mem;
  logic [15:0] lsel_where;
  logic        ld_cap;
  logic [15:0] ld_val;
  logic [31:0] prod;
  logic [16:0] rem_sh;
  logic        ge;
  logic [15:0] tmod;

  assign op   = ir_q[15:12];
  assign alt  = ir_q[11];
  assign cond = ir_q[10];
  assign mode = k_q ? ir_q[3:0] : ir_q[7:4];
  assign prod = 32'(a_q) * 32'(b_q);
  assign lsel_mem   = ld_sel_q ? p1_mem_q : p0_mem_q;
  assign lsel_where = ld_sel_q ? p1_where_q : p0_where_q;
  assign rem_sh = {rem_q, dvd_q[31]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    unique case (rf_raddr)
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4: rf_rdata = rf_q[rf_raddr];
      RegPc:   rf_rdata = pc_q;
      RegSp:   rf_rdata = sp_q;
      default: rf_rdata = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;  clr_d = clr_q;  rf_d = rf_q;
    pc_d = pc_q;  sp_d = sp_q;  truth_d = truth_q;  halt_d = halt_q;
    item_d = item_q;  ir_d = ir_q;  k_d = k_q;  imm_addr_d = imm_addr_q;
    p0_mem_d = p0_mem_q;  p0_where_d = p0_where_q;
    p1_mem_d = p1_mem_q;  p1_where_d = p1_where_q;
    ld_sel_d = ld_sel_q;  ld_two_d = ld_two_q;  a_d = a_q;  b_d = b_q;
    dvd_d = dvd_q;  dvs_d = dvs_q;  rem_d = rem_q;  cnt_d = cnt_q;
    kind_d = kind_q;  con_d = con_q;  val_d = val_q;
    mem_we = 1'b0;  mem_addr = pc_q;  mem_wdata = '0;
    rf_raddr = mode[2:0];  rf_we = 1'b0;  rf_waddr = '0;  rf_wdata = '0;
    st_en = 1'b0;  st_mem = 1'b0;  st_where = '0;  st_val = '0;
    res_en = 1'b0;  res = '0;  held = '0;  ld_cap = 1'b0;  ld_val = '0;
    tmod = '0;

    unique case (state_q)
      StClr: begin
        mem_we = 1'b1;  mem_addr = clr_q;
        clr_d = clr_q + 16'd1;
        if (clr_q == 16'hffff) state_d = StIdle;
      end
      StIdle: begin
        if (start) begin
          item_d = item_i;
          kind_d = wcpu_pkg::KindNone;  val_d = '0;  con_d = '0;
          k_d = 1'b0;
          if (!item_i.command) begin
            mem_we = 1'b1;  mem_addr = item_i.load_address;
            mem_wdata = item_i.load_data;
            state_d = StDone;
          end else if (halt_q) begin
            state_d = StDone;
          end else begin
            mem_addr = pc_q;  pc_d = pc_q + 16'd1;
            state_d = StFetch;
          end
        end
      end
      StFetch: begin
        ir_d = mem_rdata_q;
        state_d = StDec;
      end
      StDec: begin
        if (mode[2:0] == RegImm) begin
          mem_addr = pc_q;  pc_d = pc_q + 16'd1;  imm_addr_d = pc_q;
          state_d = StImm;
        end else begin
          held = rf_rdata;
          if (k_q) begin
            p1_mem_d = mode[3];  p1_where_d = mode[3] ? held : {13'd0, mode[2:0]};
            state_d = StExec;
          end else begin
            p0_mem_d = mode[3];  p0_where_d = mode[3] ? held : {13'd0, mode[2:0]};
            k_d = 1'b1;
          end
        end
      end
      StImm: begin
        held = mem_rdata_q;
        if (k_q) begin
          p1_mem_d = 1'b1;  p1_where_d = mode[3] ? held : imm_addr_q;
          state_d = StExec;
        end else begin
          p0_mem_d = 1'b1;  p0_where_d = mode[3] ? held : imm_addr_q;
          k_d = 1'b1;  state_d = StDec;
        end
      end
      StExec: begin
        k_d = 1'b0;
        if (cond && !truth_q) begin
          state_d = StDone;
        end else begin
          unique case (op)
            OpMov: begin
              ld_sel_d = 1'b1;  ld_two_d = 1'b0;  state_d = StLoad;
            end
            OpPush: begin
              ld_sel_d = 1'b0;  ld_two_d = 1'b0;  state_d = StLoad;
            end
            OpPop: begin
              sp_d = sp_q - 16'd1;  mem_addr = sp_q - 16'd1;
              state_d = StPopW;
            end
            OpCall: begin
              st_en = 1'b1;  st_mem = 1'b1;  st_where = sp_q;  st_val = pc_q;
              sp_d = sp_q + 16'd1;
              ld_sel_d = 1'b0;  ld_two_d = 1'b0;  state_d = StLoad;
            end
            default: begin
              // remainder reads operand 1 first
              ld_sel_d = (op == OpRem);  ld_two_d = 1'b1;  state_d = StLoad;
            end
          endcase
        end
      end
      StLoad: begin
        rf_raddr = lsel_where[2:0];
        if (!lsel_mem) begin
          ld_cap = 1'b1;  ld_val = rf_rdata;
        end else if (lsel_where == wcpu_pkg::PortChar) begin
          ld_cap = 1'b1;
          ld_val = (con_q == 2'd0) ? item_q.console_first :
                   (con_q == 2'd1) ? item_q.console_second : 16'hffff;
          con_d = (con_q == 2'd2) ? con_q : con_q + 2'd1;
        end else begin
          mem_addr = lsel_where;  state_d = StLwait;
        end
      end
      StLwait: begin
        ld_cap = 1'b1;  ld_val = mem_rdata_q;
      end
      StAlu: begin
        state_d = StDone;
        case (op)
          OpMov: begin res_en = 1'b1;  res = b_q; end
          OpAdd: begin res_en = 1'b1;  res = alt ? a_q - b_q : a_q + b_q; end
          OpMul: begin res_en = 1'b1;  res = alt ? prod[31:16] : prod[15:0]; end
          OpDiv: begin
            if (b_q == '0) begin
              res_en = 1'b1;  res = 16'hffff;
            end else begin
              dvd_d = alt ? {a_q, 16'd0} : {16'd0, a_q};
              dvs_d = b_q;  rem_d = '0;  cnt_d = '0;  state_d = StDiv;
            end
          end
          OpRem: begin
            if (b_q == '0) begin
              res_en = 1'b1;  res = a_q;
            end else begin
              dvd_d = {16'd0, a_q[15] ? 16'(-a_q) : a_q};
              dvs_d = b_q[15] ? 16'(-b_q) : b_q;
              rem_d = '0;  cnt_d = '0;  state_d = StDiv;
            end
          end
          OpShr: begin res_en = 1'b1;  res = a_q >> b_q[3:0]; end
          OpShl: begin res_en = 1'b1;  res = a_q << b_q[3:0]; end
          OpOr:  begin res_en = 1'b1;  res = a_q | b_q; end
          OpAnd: begin res_en = 1'b1;  res = a_q & b_q; end
          OpXor: begin res_en = 1'b1;  res = a_q ^ b_q; end
          OpEq:  truth_d = alt ^ (a_q == b_q);
          OpGtu: truth_d = alt ^ (a_q > b_q);
          OpGts: truth_d = alt ^ ((a_q ^ 16'h8000) > (b_q ^ 16'h8000));
          OpPush: begin
            st_en = 1'b1;  st_mem = 1'b1;  st_where = sp_q;  st_val = a_q;
            sp_d = sp_q + 16'd1;
          end
          OpCall: pc_d = a_q;
          default: ;
        endcase
      end
      StDiv: begin
        rem_d = ge ? 16'(rem_sh - {1'b0, dvs_q}) : rem_sh[15:0];
        dvd_d = {dvd_q[30:0], ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) state_d = StDivE;
      end
      StDivE: begin
        res_en = 1'b1;  state_d = StDone;
        if (op == OpDiv) begin
          res = dvd_q[15:0];
        end else begin
          // truncated remainder takes A's sign; alt adds B if A < 0 and rem != 0
          tmod = a_q[15] ? 16'(-rem_q) : rem_q;
          res = (alt && a_q[15] && rem_q != '0) ? tmod + b_q : tmod;
        end
      end
      StPopW: begin
        res_en = 1'b1;  res = mem_rdata_q;  state_d = StDone;
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase

    // operand capture and load sequencing
    if (ld_cap) begin
      if (ld_sel_q) b_d = ld_val;
      else a_d = ld_val;
      if (ld_two_q) begin
        ld_two_d = 1'b0;  ld_sel_d = ~ld_sel_q;  state_d = StLoad;
      end else begin
        state_d = StAlu;
      end
    end

    if (res_en) begin
      st_en = 1'b1;  st_mem = p0_mem_q;  st_where = p0_where_q;  st_val = res;
    end

    // store with port decode
    if (st_en) begin
      if (!st_mem) begin
        rf_we = 1'b1;  rf_waddr = st_where[2:0];  rf_wdata = st_val;
      end else if (st_where == wcpu_pkg::PortChar) begin
        kind_d = wcpu_pkg::KindChar;  val_d = st_val;
      end else if (st_where == wcpu_pkg::PortHex) begin
        kind_d = wcpu_pkg::KindHex;  val_d = st_val;
      end else if (st_where == wcpu_pkg::PortDec) begin
        kind_d = wcpu_pkg::KindDec;  val_d = st_val;
      end else begin
        mem_we = 1'b1;  mem_addr = st_where;  mem_wdata = st_val;
      end
    end

    if (rf_we) begin
      unique case (rf_waddr)
        RegPc:   pc_d = rf_wdata;
        RegSp:   sp_d = rf_wdata;
        default: rf_d[rf_waddr] = rf_wdata;
      endcase
    end

    // shadow of the halt word
    if (mem_we && mem_addr == wcpu_pkg::HaltAddr) halt_d = (mem_wdata != '0);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    mem_rdata_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;  clr_q <= '0;
      rf_q <= '{default: '0};  pc_q <= '0;  sp_q <= '0;
      truth_q <= 1'b0;  halt_q <= 1'b0;  k_q <= 1'b0;
      ld_sel_q <= 1'b0;  ld_two_q <= 1'b0;  cnt_q <= '0;
      kind_q <= '0;  con_q <= '0;  val_q <= '0;
    end else begin
      state_q <= state_d;  clr_q <= clr_d;
      rf_q <= rf_d;  pc_q <= pc_d;  sp_q <= sp_d;
      truth_q <= truth_d;  halt_q <= halt_d;  k_q <= k_d;
      ld_sel_q <= ld_sel_d;  ld_two_q <= ld_two_d;  cnt_q <= cnt_d;
      kind_q <= kind_d;  con_q <= con_d;  val_q <= val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;  ir_q <= ir_d;  imm_addr_q <= imm_addr_d;
    p0_mem_q <= p0_mem_d;  p0_where_q <= p0_where_d;
    p1_mem_q <= p1_mem_d;  p1_where_q <= p1_where_d;
    a_q <= a_d;  b_q <= b_d;
    dvd_q <= dvd_d;  dvs_q <= dvs_d;  rem_q <= rem_d;
  end

  assign busy        = (state_q != StIdle);
  assign out_valid_o = (state_q == StDone);
  assign result_o.out_kind     = kind_q;
  assign result_o.out_value    = val_q;
  assign result_o.console_used = con_q;
  assign result_o.halted       = halt_q;

endmodule

// ===== tb/sv/wcpu_checker.sv =====
`timescale 1ns / 100ps

module wcpu_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  wcpu_pkg::item_t   item_i,
  input  logic              out_valid_i,
  input  wcpu_pkg::result_t result_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam logic [2:0] RegPc = 3'd5;
  localparam logic [2:0] RegSp = 3'd6;

  typedef enum logic [3:0] {
    OpMove, OpAddSub, OpMul, OpDiv, OpRem, OpShr, OpShl, OpOr,
    OpAnd, OpXor, OpCmpEq, OpCmpGtu, OpCmpGts, OpPush, OpPop, OpCall
  } opcode_e;

  typedef struct {
    logic        in_mem;
    logic [15:0] where;
  } operand_t;

  logic [15:0] mem_model [65536];
  logic [15:0] regs [7];
  logic        truth;
  logic [15:0] con_word [2];
  int          con_reads;
  int          fail_count;
  wcpu_pkg::result_t step_res;
  wcpu_pkg::result_t expected_q [$];

  function automatic operand_t resolve(logic [3:0] mode);
    operand_t o;
    logic [15:0] held;
    if (mode[2:0] == 3'd7) begin
      o.in_mem = 1'b1;
      o.where = regs[RegPc];
      held = mem_model[regs[RegPc]];
      regs[RegPc] = regs[RegPc] + 16'd1;
    end else begin
      o.in_mem = 1'b0;
      o.where = {13'd0, mode[2:0]};
      held = regs[mode[2:0]];
    end
    if (mode[3]) begin
      o.in_mem = 1'b1;
      o.where = held;
    end
    return o;
  endfunction

  function automatic logic [15:0] read_op(operand_t o);
    logic [15:0] v;
    if (!o.in_mem) return regs[o.where[2:0]];
    if (o.where == wcpu_pkg::PortChar) begin
      v = (con_reads < 2) ? con_word[con_reads[0]] : 16'hffff;
      con_reads++;
      return v;
    end
    return mem_model[o.where];
  endfunction

  function automatic void write_mem(logic [15:0] addr, logic [15:0] v);
    if (addr == wcpu_pkg::PortChar) begin
      step_res.out_kind = wcpu_pkg::KindChar; step_res.out_value = v;
    end else if (addr == wcpu_pkg::PortHex) begin
      step_res.out_kind = wcpu_pkg::KindHex; step_res.out_value = v;
    end else if (addr == wcpu_pkg::PortDec) begin
      step_res.out_kind = wcpu_pkg::KindDec; step_res.out_value = v;
    end else begin
      mem_model[addr] = v;
    end
  endfunction

  function automatic void write_op(operand_t o, logic [15:0] v);
    if (o.in_mem) write_mem(o.where, v);
    else regs[o.where[2:0]] = v;
  endfunction

  function automatic void push_word(logic [15:0] v);
    logic [15:0] s;
    s = regs[RegSp];
    regs[RegSp] = s + 16'd1;
    write_mem(s, v);
  endfunction

  function automatic void run_instruction();
    logic [15:0] code, a, b, sp_new;
    opcode_e     op;
    operand_t    p0, p1;
    logic        alt;
    logic [31:0] wide;
    int          sa, sb, rem;
    code = mem_model[regs[RegPc]];
    regs[RegPc] = regs[RegPc] + 16'd1;
    op = opcode_e'(code[15:12]);
    p0 = resolve(code[7:4]);
    p1 = resolve(code[3:0]);
    alt = code[11];
    if (code[10] && !truth) return;
    case (op)
      OpMove: write_op(p0, read_op(p1));
      OpAddSub: begin
        a = read_op(p0); b = read_op(p1);
        write_op(p0, alt ? a - b : a + b);
      end
      OpMul: begin
        a = read_op(p0); b = read_op(p1);
        wide = 32'(a) * 32'(b);
        write_op(p0, alt ? wide[31:16] : wide[15:0]);
      end
      OpDiv: begin
        a = read_op(p0); b = read_op(p1);
        if (b == 0) begin
          write_op(p0, 16'hffff);
        end else begin
          wide = alt ? {a, 16'd0} : {16'd0, a};
          wide = wide / 32'(b);
          write_op(p0, wide[15:0]);
        end
      end
      OpRem: begin
        // divisor is read first here
        b = read_op(p1); a = read_op(p0);
        sa = $signed(a); sb = $signed(b);
        if (sb == 0) begin
          write_op(p0, a);
        end else begin
          rem = sa % sb;
          if (alt && rem < 0) rem += sb;
          write_op(p0, rem[15:0]);
        end
      end
      OpShr: begin a = read_op(p0); b = read_op(p1); write_op(p0, a >> b[3:0]); end
      OpShl: begin a = read_op(p0); b = read_op(p1); write_op(p0, a << b[3:0]); end
      OpOr:  begin a = read_op(p0); b = read_op(p1); write_op(p0, a | b); end
      OpAnd: begin a = read_op(p0); b = read_op(p1); write_op(p0, a & b); end
      OpXor: begin a = read_op(p0); b = read_op(p1); write_op(p0, a ^ b); end
      OpCmpEq:  begin a = read_op(p0); b = read_op(p1); truth = alt ^ (a == b); end
      OpCmpGtu: begin a = read_op(p0); b = read_op(p1); truth = alt ^ (a > b); end
      OpCmpGts: begin
        a = read_op(p0); b = read_op(p1);
        truth = alt ^ ($signed(a) > $signed(b));
      end
      OpPush: begin a = read_op(p0); push_word(a); end
      OpPop: begin
        sp_new = regs[RegSp] - 16'd1;
        regs[RegSp] = sp_new;
        write_op(p0, mem_model[sp_new]);
      end
      default: begin
        push_word(regs[RegPc]);
        a = read_op(p0);
        regs[RegPc] = a;
      end
    endcase
  endfunction

  function automatic wcpu_pkg::result_t predict_transfer(wcpu_pkg::item_t it);
    step_res = '0;
    con_reads = 0;
    con_word[0] = it.console_first;
    con_word[1] = it.console_second;
    if (!it.command) mem_model[it.load_address] = it.load_data;
    else if (mem_model[wcpu_pkg::HaltAddr] == 0) run_instruction();
    step_res.console_used = (con_reads > 2) ? 2'd2 : 2'(con_reads);
    step_res.halted = (mem_model[wcpu_pkg::HaltAddr] != 0);
    return step_res;
  endfunction

  assign pending_o = expected_q.size();
  assign fail_count_o = fail_count;

  always @(posedge clk_i) begin
    wcpu_pkg::result_t exp_r;
    if (!rst_ni) begin
      foreach (mem_model[i]) mem_model[i] = '0;
      foreach (regs[i]) regs[i] = '0;
      truth = 1'b0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (start_i && !busy_i) expected_q.push_back(predict_transfer(item_i));
      if (out_valid_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result_i);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (result_i.out_kind !== exp_r.out_kind ||
              result_i.out_value !== exp_r.out_value ||
              result_i.console_used !== exp_r.console_used ||
              result_i.halted !== exp_r.halted) begin
            $display("%0t: mismatch expected kind=%0d value=%h used=%0d halted=%0d",
                     $time, exp_r.out_kind, exp_r.out_value, exp_r.console_used,
                     exp_r.halted);
            $display("%0t:          actual   kind=%0d value=%h used=%0d halted=%0d",
                     $time, result_i.out_kind, result_i.out_value,
                     result_i.console_used, result_i.halted);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  // watchdog: idle cycles with no transfer; covers the 64K clearing pass
  localparam int WatchdogLimit = 400000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  wcpu_pkg::item_t   item_q = '0;
  logic    out_valid_o;
  wcpu_pkg::result_t result_o;
  int      fail_count;
  int      pending;
  int      idle_cycles = 0;

  // a small program area; most steps run inside it so that control flow
  // stays among loaded words instead of wandering through zeros
  logic [15:0] code_base;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  word_cpu_instruction_step dut (
    .clk_i, .rst_ni, .start, .busy, .item_i(item_q), .out_valid_o, .result_o
  );

  wcpu_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .item_i(item_q),
    .out_valid_i(out_valid_o), .result_i(result_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog: any transfer or result resets the count
  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // one transfer: random gap, then hold start until busy is low at an edge;
  // start stays high into the next transfer when that one has no gap
  task automatic send(input logic cmd, input logic [15:0] addr, input logic [15:0] data,
                      input logic [15:0] con0, input logic [15:0] con1);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_q <= '{command: cmd, load_address: addr, load_data: data,
                console_first: con0, console_second: con1};
    do @(posedge clk_i); while (busy);
  endtask

  task automatic load_word(input logic [15:0] addr, input logic [15:0] data);
    send(1'b0, addr, data, 16'($urandom), 16'($urandom));
  endtask

  task automatic step_once();
    logic [15:0] c0, c1;
    c0 = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom);
    c1 = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom);
    send(1'b1, 16'($urandom), 16'($urandom), c0, c1);
  endtask

  // operand mode: uniformly random over all sixteen modes
  function automatic logic [3:0] pick_mode();
    return 4'($urandom);
  endfunction

  function automatic logic [15:0] pick_data();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      3: return wcpu_pkg::PortChar + 16'($urandom_range(0, 2));
      4: return code_base + 16'($urandom_range(0, 31));
      default: return 16'($urandom);
    endcase
  endfunction

  // random instruction word with random operand modes
  function automatic logic [15:0] pick_instr();
    logic [15:0] w;
    w = 16'($urandom);
    w[7:4] = pick_mode();
    w[3:0] = pick_mode();
    return w;
  endfunction

  // set pc and sp through a short program of moves
  task automatic set_reg(input int r, input logic [15:0] v);
    // move r <- immediate, placed at current code_base, then stepped
    load_word(code_base, {4'h0, 4'h0, 4'(r), 4'h7});
    load_word(code_base + 16'd1, v);
    step_once();
  endtask

  initial begin
    int n;
    int total;
    code_base = 16'h0000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part: pc starts at 0
    // move R0 <- 0xffff ; add R0 += 1 (wraps) ; print R0 to the hex port
    load_word(16'h0000, 16'h0007); load_word(16'h0001, 16'hffff);
    load_word(16'h0002, 16'h1007); load_word(16'h0003, 16'h0001);
    load_word(16'h0004, 16'h00f0); load_word(16'h0005, wcpu_pkg::PortHex);
    // console move: [imm ff00] <- [imm ff00] echoes first console word
    load_word(16'h0006, 16'h00ff); load_word(16'h0007, wcpu_pkg::PortChar);
    load_word(16'h0008, wcpu_pkg::PortChar);
    // conditional alt remainder: decimal port word by a console word
    load_word(16'h0009, 16'h4cff); load_word(16'h000a, wcpu_pkg::PortDec);
    load_word(16'h000b, wcpu_pkg::PortChar);
    repeat (4) step_once();
    // divide by zero, alt multiply, push R0, call
    load_word(16'h000c, 16'h3007); load_word(16'h000d, 16'h0000);
    load_word(16'h000e, 16'h2807); load_word(16'h000f, 16'hffff);
    load_word(16'h0010, 16'hd000);
    load_word(16'h0011, 16'hf070); load_word(16'h0012, 16'h0013);
    repeat (4) step_once();
    // halt: nonzero word at the halt address, step, then clear it
    load_word(wcpu_pkg::HaltAddr, 16'h0001);
    step_once();
    load_word(wcpu_pkg::HaltAddr, 16'h0000);

    // random part: segments of program words then steps through them
    total = 30;
    while (total < 1650) begin
      code_base = ($urandom_range(0, 3) == 0) ? 16'($urandom) & 16'hffc0
                                               : 16'h0100;
      if (code_base >= 16'hff00) code_base = 16'h0100;
      set_reg(5, code_base);
      set_reg(6, ($urandom_range(0, 3) == 0) ? 16'hfefe : code_base + 16'd64);
      for (int i = 0; i < 32; i++) begin
        load_word(code_base + 16'(i), ($urandom_range(0, 1) == 0) ? pick_instr()
                                                                  : pick_data());
      end
      // some stray data words, including the halt word now and then
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) load_word(pick_data(), pick_data());
      if ($urandom_range(0, 15) == 0) load_word(wcpu_pkg::HaltAddr, 16'($urandom));
      n = $urandom_range(10, 30);
      for (int i = 0; i < n; i++) step_once();
      load_word(wcpu_pkg::HaltAddr, 16'h0000);
      total += 38 + n + 4;
    end
    start <= 1'b0;

    // drain, then a short settling tail
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
